// ===== rtl/mnrs_pkg.sv =====
package mnrs_pkg;

  localparam int PITCH_W = 7;
  localparam int VEL_IN_W = 16;
  localparam int VEL_W = 7;
  localparam int DUR_IN_W = 20;
  localparam int PEND_W = 7;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    FUNC_PLAY  = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_PROC,
    ST_END
  } ctl_state_t;

  typedef struct packed {
    logic play;
    logic clear;
    logic start;
    logic rd;
    logic keep;
    logic rel_push;
    logic rel_hold;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic at_end;
    logic expire;
    logic hold_valid;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/mnrs_ram.sv =====
module mnrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/mnrs_ctrl.sv =====
module mnrs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [1:0]         func,
  input  mnrs_pkg::dp_sts_t  sts,
  output mnrs_pkg::dp_cmd_t  cmd
);
  import mnrs_pkg::*;

  ctl_state_t state_r, state_nxt;
  func_t f;

  assign f = func_t'(func);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = sts.out_free;
        if (in_tvalid && sts.out_free) begin
          unique case (f)
            FUNC_PLAY: cmd.play = 1'b1;
            FUNC_CLEAR: cmd.clear = 1'b1;
            FUNC_TICK, FUNC_STOP: begin
              cmd.start = 1'b1;
              state_nxt = ST_RD;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        if (sts.at_end) begin
          state_nxt = ST_END;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = ST_PROC;
        end
      end
      ST_PROC: begin
        priority if (!sts.expire) begin
          cmd.keep = 1'b1;
          state_nxt = ST_RD;
        end else if (!sts.hold_valid) begin
          cmd.rel_hold = 1'b1;
          state_nxt = ST_RD;
        end else if (sts.out_free) begin
          cmd.rel_push = 1'b1;
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_PROC;
        end
      end
      ST_END: begin
        priority if (!sts.hold_valid) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_END;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/mnrs_dp.sv =====
module mnrs_dp #(
  parameter int SLOTS = 64,
  parameter int DURATION_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [1:0]                    func,
  input  logic [mnrs_pkg::PITCH_W-1:0]  pitch,
  input  logic [mnrs_pkg::VEL_IN_W-1:0] velocity,
  input  logic [mnrs_pkg::DUR_IN_W-1:0] duration,
  input  mnrs_pkg::dp_cmd_t             cmd,
  output mnrs_pkg::dp_sts_t             sts,
  input  logic                          out_tready,
  output logic                          out_valid,
  output logic [mnrs_pkg::PITCH_W-1:0]  pitch_out,
  output logic [mnrs_pkg::VEL_W-1:0]    velocity_out,
  output logic                          refused,
  output logic [mnrs_pkg::PEND_W-1:0]   pending,
  output logic                          last
);
  import mnrs_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = PITCH_W + DURATION_BITS;
  localparam logic [32:0] DMAX = (33'd1 << DURATION_BITS) - 33'd1;

  logic [CW-1:0] cnt_r, n_r, rd_r, wr_r;
  logic          stop_r;
  logic          hold_valid_r;
  logic [PITCH_W-1:0] hold_pitch_r;
  logic [PEND_W-1:0]  hold_pend_r;
  logic          out_valid_r;
  logic [PITCH_W-1:0] pitch_r;
  logic [VEL_W-1:0]   vel_r;
  logic          refused_r, last_r;
  logic [PEND_W-1:0]  pend_r;

  logic [VEL_W-1:0] vel;
  logic [32:0] dur_ext;
  logic [DURATION_BITS-1:0] dur_sat;
  logic full;
  logic [CW-1:0] cnt_dec;
  logic [EW-1:0] rdata, wdata;
  logic [DURATION_BITS-1:0] rem, rem_dec;
  logic [PITCH_W-1:0] rpitch;
  logic we;
  logic [AW-1:0] waddr;

  assign vel = velocity[VEL_IN_W-1] ? '0 :
               (|velocity[VEL_IN_W-2:VEL_W]) ? {VEL_W{1'b1}} : velocity[VEL_W-1:0];
  assign dur_ext = {{(33-DUR_IN_W){1'b0}}, duration};
  always_comb begin
    if (dur_ext > DMAX) begin
      dur_sat = DMAX[DURATION_BITS-1:0];
    end else if (dur_ext == 33'd0) begin
      dur_sat = DURATION_BITS'(1);
    end else begin
      dur_sat = dur_ext[DURATION_BITS-1:0];
    end
  end

  assign full = (cnt_r == CW'(SLOTS));
  assign cnt_dec = cnt_r - CW'(1);
  assign rpitch = rdata[EW-1:DURATION_BITS];
  assign rem = rdata[DURATION_BITS-1:0];
  assign rem_dec = rem - DURATION_BITS'(1);

  assign we = (cmd.play && vel != '0 && !full) || cmd.keep;
  assign waddr = cmd.keep ? wr_r[AW-1:0] : cnt_r[AW-1:0];
  assign wdata = cmd.keep ? {rpitch, rem_dec} : {pitch, dur_sat};

  mnrs_ram #(.WIDTH(EW), .DEPTH(SLOTS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (rd_r[AW-1:0]),
    .rdata (rdata)
  );

  assign sts.at_end = (rd_r == n_r);
  assign sts.expire = stop_r || (rem == DURATION_BITS'(1));
  assign sts.hold_valid = hold_valid_r;
  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      n_r <= '0;
      rd_r <= '0;
      wr_r <= '0;
      stop_r <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.play) begin
        out_valid_r <= 1'b1;
        if (vel != '0 && !full) begin
          cnt_r <= cnt_r + CW'(1);
        end
      end
      if (cmd.clear) begin
        cnt_r <= '0;
      end
      if (cmd.start) begin
        n_r <= cnt_r;
        rd_r <= '0;
        wr_r <= '0;
        stop_r <= (func_t'(func) == FUNC_STOP);
        hold_valid_r <= 1'b0;
      end
      if (cmd.rd) begin
        rd_r <= rd_r + CW'(1);
      end
      if (cmd.keep) begin
        wr_r <= wr_r + CW'(1);
      end
      if (cmd.rel_hold || cmd.rel_push) begin
        cnt_r <= cnt_dec;
        hold_valid_r <= 1'b1;
      end
      if (cmd.rel_push) begin
        out_valid_r <= 1'b1;
      end
      if (cmd.flush) begin
        out_valid_r <= 1'b1;
        hold_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.play) begin
      pitch_r <= pitch;
      vel_r <= vel;
      refused_r <= (vel != '0) && full;
      pend_r <= (vel != '0 && !full) ? PEND_W'(cnt_r + CW'(1)) : PEND_W'(cnt_r);
      last_r <= 1'b1;
    end
    if (cmd.rel_push || cmd.flush) begin
      pitch_r <= hold_pitch_r;
      vel_r <= '0;
      refused_r <= 1'b0;
      pend_r <= hold_pend_r;
      last_r <= cmd.flush;
    end
    if (cmd.rel_hold || cmd.rel_push) begin
      hold_pitch_r <= rpitch;
      hold_pend_r <= PEND_W'(cnt_dec);
    end
  end

  assign out_valid = out_valid_r;
  assign pitch_out = pitch_r;
  assign velocity_out = vel_r;
  assign refused = refused_r;
  assign pending = pend_r;
  assign last = last_r;

endmodule

// ===== rtl/midi_note_release_scheduler.sv =====
// Channel  Direction  Contents
// in_      request    tdata: func[1:0] pitch[8:2] velocity[24:9] duration[44:25]
// out_     result     tdata: pitch_out velocity_out pending; tuser: refused; tlast: last
//
// A play or a clear is taken in the idle state; a tick or stop with no armed note goes
// through the read and end states. A tick or stop walks the armed-note list in play order,
// a read and a process state per note, writing kept notes back through the RAM write port.
// Reset empties the list at once; no clearing pass is needed.
// A stalled output holds the walk until the pending result is taken.
module midi_note_release_scheduler #(
  parameter int SLOTS = 64,
  parameter int DURATION_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mnrs_pkg::IN_DATA_W-1:0]    in_tdata,  // func, pitch, velocity, duration
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mnrs_pkg::OUT_DATA_W-1:0]   out_tdata, // pitch_out, velocity_out, pending
  output logic                              out_tuser, // refused
  output logic                              out_tlast
);
  import mnrs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [PITCH_W-1:0] pitch_out;
  logic [VEL_W-1:0] velocity_out;
  logic [PEND_W-1:0] pending;

  mnrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .func      (in_tdata[1:0]),
    .sts       (sts),
    .cmd       (cmd)
  );

  mnrs_dp #(.SLOTS(SLOTS), .DURATION_BITS(DURATION_BITS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .func         (in_tdata[1:0]),
    .pitch        (in_tdata[8:2]),
    .velocity     (in_tdata[24:9]),
    .duration     (in_tdata[44:25]),
    .cmd          (cmd),
    .sts          (sts),
    .out_tready   (out_tready),
    .out_valid    (out_tvalid),
    .pitch_out    (pitch_out),
    .velocity_out (velocity_out),
    .refused      (out_tuser),
    .pending      (pending),
    .last         (out_tlast)
  );

  assign out_tdata = {3'b000, pending, velocity_out, pitch_out};

endmodule

// ===== bench/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mnrs_pkg::*;

  typedef struct packed {
    logic [6:0] pitch;
    logic [6:0] vel;
    logic       refused;
    logic [6:0] pend;
    logic       last;
  } note_event_t;

  class note_scoreboard;
    bit         armed[64];
    bit [6:0]   pitch_of[64];
    bit [19:0]  ticks_left[64];
    bit [31:0]  ticket_of[64];
    bit [31:0]  ticket;
    note_event_t due[$];
    int         errors;

    function int armed_count();
      int n;
      n = 0;
      foreach (armed[i]) n += armed[i];
      return n;
    endfunction

    function void release_set(int lst[$]);
      int cur;
      int b;
      int pend;
      note_event_t ev;
      for (int a = 1; a < lst.size(); a++) begin
        cur = lst[a];
        b = a;
        while (b > 0 && (ticket - ticket_of[lst[b-1]]) < (ticket - ticket_of[cur])) begin
          lst[b] = lst[b-1];
          b--;
        end
        lst[b] = cur;
      end
      foreach (lst[k]) armed[lst[k]] = 0;
      pend = armed_count() + lst.size();
      foreach (lst[k]) begin
        pend--;
        ev.pitch = pitch_of[lst[k]];
        ev.vel = 0;
        ev.refused = 0;
        ev.pend = 7'(pend);
        ev.last = (k == lst.size() - 1);
        due.push_back(ev);
      end
    endfunction

    function void note_request(logic [44:0] d);
      func_t      f;
      logic [6:0] p;
      logic [15:0] v;
      logic [19:0] dur;
      int         vel;
      int         idx;
      int         lst[$];
      note_event_t ev;
      f = func_t'(d[1:0]);
      p = d[8:2];
      v = d[24:9];
      dur = d[44:25];
      case (f)
        FUNC_PLAY: begin
          vel = v[15] ? 0 : (v > 127 ? 127 : int'(v));
          ev.pitch = p;
          ev.vel = 7'(vel);
          ev.refused = 0;
          ev.last = 1;
          idx = -1;
          if (vel != 0) begin
            for (int i = 0; i < 64; i++) if (!armed[i] && idx < 0) idx = i;
            if (idx < 0) ev.refused = 1;
            else begin
              armed[idx] = 1;
              pitch_of[idx] = p;
              ticks_left[idx] = (dur == 0) ? 20'd1 : dur;
              ticket_of[idx] = ticket;
              ticket++;
            end
          end
          ev.pend = 7'(armed_count());
          due.push_back(ev);
        end
        FUNC_TICK: begin
          for (int i = 0; i < 64; i++) if (armed[i]) begin
            if (ticks_left[i] > 0) ticks_left[i]--;
            if (ticks_left[i] == 0) lst.push_back(i);
          end
          release_set(lst);
        end
        FUNC_STOP: begin
          for (int i = 0; i < 64; i++) if (armed[i]) lst.push_back(i);
          release_set(lst);
        end
        default: foreach (armed[i]) armed[i] = 0;
      endcase
    endfunction

    function void check_event(note_event_t got);
      note_event_t exp_ev;
      if (due.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_ev = due.pop_front();
      if (got !== exp_ev) begin
        $display("%0t: mismatch expected p=%0d v=%0d r=%0d n=%0d l=%0d",
                 $time, exp_ev.pitch, exp_ev.vel, exp_ev.refused, exp_ev.pend, exp_ev.last);
        $display("%0t:          got p=%0d v=%0d r=%0d n=%0d l=%0d",
                 $time, got.pitch, got.vel, got.refused, got.pend, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  note_scoreboard sb;
  int idle_cycles;
  bit long_hold;

  midi_note_release_scheduler u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic send_request(func_t f, logic [6:0] p, logic [15:0] v, logic [19:0] d);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {3'b0, d, v, p, f};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request({d, v, p, f});
  endtask

  task automatic send_play(logic [6:0] p, logic [15:0] v, logic [19:0] d);
    send_request(FUNC_PLAY, p, v, d);
  endtask

  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      send_play(7'($urandom),
                16'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 127)),
                20'($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 6)));
    else if (r < 90) send_request(FUNC_TICK, 7'($urandom), 16'($urandom), 20'($urandom));
    else if (r < 96) send_request(FUNC_STOP, 7'($urandom), 16'($urandom), 20'($urandom));
    else send_request(FUNC_CLEAR, 7'($urandom), 16'($urandom), 20'($urandom));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_event({out_tdata[6:0], out_tdata[13:7], out_tuser, out_tdata[20:14], out_tlast});
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int g;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_tready <= 0;
        repeat (400) @(posedge clk);
        long_hold = 0;
      end
      g = gap_len();
      if (g > 0) begin
        out_tready <= 0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    sb = new();
    idle_cycles = 0;
    long_hold = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_request(FUNC_TICK, 7'd0, 16'd0, 20'd0);
    send_request(FUNC_STOP, 7'h7f, 16'hffff, 20'hfffff);
    send_play(7'd0, 16'h8000, 20'd5);
    send_play(7'h7f, 16'h7fff, 20'hfffff);
    send_play(7'd60, 16'd127, 20'd0);
    send_play(7'd61, 16'd128, 20'd1);
    send_play(7'd62, 16'd1, 20'd2);
    send_play(7'd63, 16'd0, 20'd3);
    send_play(7'd64, 16'hffff, 20'd3);
    send_request(FUNC_TICK, 7'd0, 16'd0, 20'd0);
    send_request(FUNC_TICK, 7'd0, 16'd0, 20'd0);
    send_request(FUNC_STOP, 7'd0, 16'd0, 20'd0);
    send_play(7'd10, 16'd90, 20'd4);
    send_request(FUNC_CLEAR, 7'd0, 16'd0, 20'd0);
    send_request(FUNC_STOP, 7'd0, 16'd0, 20'd0);
    long_hold = 1;
    for (int i = 0; i < 66; i++)
      send_play(7'(i), 16'($urandom_range(1, 127)), 20'($urandom_range(0, 3)));
    send_request(FUNC_TICK, 7'd0, 16'd0, 20'd0);
    send_request(FUNC_STOP, 7'd0, 16'd0, 20'd0);
    for (int i = 0; i < 347; i++) random_request();
    in_tvalid <= 0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
